// File: src/decimal_length_prefix_deframer_top_assert.svh
// Assertion macros for the decimal length-prefix deframer checker.
`ifndef DECIMAL_LENGTH_PREFIX_DEFRAMER_TOP_ASSERT_SVH
`define DECIMAL_LENGTH_PREFIX_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define DLPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define DLPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dlpd_pkg.sv
// Shared types and constants for the decimal length-prefix deframer.
package dlpd_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] count_t;
    typedef logic [1:0]  error_t;

    localparam count_t MAX_PAYLOAD = 16'd65535;

    localparam byte_t CHAR_0 = 8'h30;
    localparam byte_t CHAR_9 = 8'h39;
    localparam logic [3:0] RADIX = 4'd10;

    localparam error_t ERR_NONE     = 2'd0;
    localparam error_t ERR_NO_DIGIT = 2'd1;
    localparam error_t ERR_ZERO_LEN = 2'd2;
    localparam error_t ERR_TOO_LONG = 2'd3;

endpackage

// File: src/decimal_length_prefix_deframer_top.sv
// Decimal length-prefix deframer: top level with header parser and output register.
//
// Takes one received byte per transaction. A frame is an ASCII decimal length
// (digits read until the first non-digit) followed by that many payload bytes;
// the non-digit that ends the header is itself the first payload byte. Each
// payload byte leaves as one transaction with last set on the final byte of a
// frame. Header digits produce no output. A malformed header yields one
// transaction with error set (1 no leading digit, 2 zero length, 3 length above
// MAX_PAYLOAD), out_byte and last zero; the offending byte is dropped and the
// parser looks for a new header. Throughput is one byte per clock while the output
// is not stalled: a byte is captured in an input register, and the parse update
// (one multiply-by-ten add and a compare) works on that register and lands in the
// output register once that register is empty or being drained. in_stall rises
// only when the output register is full and held by out_stall while a captured
// byte waits.
module decimal_length_prefix_deframer_top
    import dlpd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  byte_t  in_byte,
    output logic   out_valid,
    input  logic   out_stall,
    output byte_t  out_byte,
    output logic   last,
    output error_t error
);

    localparam logic ST_HEADER  = 1'b0;
    localparam logic ST_PAYLOAD = 1'b1;

    // input stage
    logic   in_valid_reg;
    byte_t  in_byte_reg;

    // parser state
    logic   state_reg, state_next;
    count_t count_reg, count_next;
    logic   seen_reg, seen_next;
    logic   ovf_reg, ovf_next;

    // output stage
    logic   out_valid_reg;
    byte_t  out_byte_reg;
    logic   out_last_reg;
    error_t out_err_reg;

    logic   advance;
    logic   is_digit;
    logic [19:0] acc_wide;
    logic   too_big;
    logic   res_valid;
    byte_t  res_byte;
    logic   res_last;
    error_t res_err;

    // Parse stage moves when the output register is empty or being drained.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    assign is_digit = (in_byte_reg >= CHAR_0) && (in_byte_reg <= CHAR_9);
    assign acc_wide = {4'd0, count_reg} * {16'd0, RADIX}
                    + {16'd0, in_byte_reg[3:0]};
    assign too_big  = acc_wide > {4'd0, MAX_PAYLOAD};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        seen_next  = seen_reg;
        ovf_next   = ovf_reg;
        res_valid  = 1'b0;
        res_byte   = in_byte_reg;
        res_last   = 1'b0;
        res_err    = ERR_NONE;
        case (state_reg)
            ST_PAYLOAD:
            begin
                res_valid = 1'b1;
                if (count_reg <= 16'd1)
                begin
                    res_last   = 1'b1;
                    state_next = ST_HEADER;
                    count_next = '0;
                    seen_next  = 1'b0;
                    ovf_next   = 1'b0;
                end
                else
                begin
                    count_next = count_reg - 16'd1;
                end
            end
            ST_HEADER:
            begin
                if (is_digit)
                begin
                    seen_next = 1'b1;
                    if (ovf_reg || too_big)
                    begin
                        ovf_next   = 1'b1;
                        count_next = MAX_PAYLOAD;
                    end
                    else
                    begin
                        count_next = acc_wide[15:0];
                    end
                end
                else
                begin
                    res_valid  = 1'b1;
                    state_next = ST_HEADER;
                    count_next = '0;
                    seen_next  = 1'b0;
                    ovf_next   = 1'b0;
                    if (!seen_reg)
                    begin
                        res_err  = ERR_NO_DIGIT;
                        res_byte = '0;
                    end
                    else if (ovf_reg)
                    begin
                        res_err  = ERR_TOO_LONG;
                        res_byte = '0;
                    end
                    else if (count_reg == 16'd0)
                    begin
                        res_err  = ERR_ZERO_LEN;
                        res_byte = '0;
                    end
                    else if (count_reg == 16'd1)
                    begin
                        res_last = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_PAYLOAD;
                        count_next = count_reg - 16'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_HEADER;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_HEADER;
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg && res_valid;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                    count_reg <= count_next;
                    seen_reg  <= seen_next;
                    ovf_reg   <= ovf_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= in_byte;
        end
        if (advance && in_valid_reg && res_valid)
        begin
            out_byte_reg <= res_byte;
            out_last_reg <= res_last;
            out_err_reg  <= res_err;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = out_last_reg;
    assign error     = out_err_reg;

endmodule

// File: src/dlpd_checker.sv
// Port-level checker for the decimal length-prefix deframer, with its bind.
`include "decimal_length_prefix_deframer_top_assert.svh"

module dlpd_checker
    import dlpd_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_stall,
    input logic   out_valid,
    input logic   out_stall,
    input byte_t  out_byte,
    input logic   last,
    input error_t error
);

    `DLPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last) && $stable(error), "stalled output transaction changed")
    `DLPD_ASSERT_NOW(a_err_clean, out_valid && error != ERR_NONE, out_byte == 8'd0 && !last, "error transaction carries data or last")
    `DLPD_ASSERT_NOW(a_empty_no_stall, !out_valid, !in_stall, "input stalled while output register empty")
    `DLPD_ASSERT_NOW(a_drain_no_stall, out_valid && !out_stall, !in_stall, "input stalled while output drains")

endmodule

bind decimal_length_prefix_deframer_top dlpd_checker u_dlpd_checker (.*);

// File: test/tb_decimal_length_prefix_deframer_top.sv
`timescale 1ns / 100ps
// Testbench for the decimal length-prefix deframer: framed byte streams checked against a behavioural parser.
module tb_decimal_length_prefix_deframer_top;
    import dlpd_pkg::*;

    // Cycles with no transaction on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last expected byte, to catch stray output.
    localparam int TAIL_CYCLES    = 16;
    localparam int DIRECTED_BYTES = 19;
    localparam int RANDOM_BYTES   = 1620;
    // Stream positions at which the idling pattern changes.
    localparam int PHASE_SPAN     = 560;
    localparam int MISMATCH_SHOWN = 10;

    // One deframed output transaction.
    typedef struct {
        byte_t  data;
        logic   fin;
        error_t err;
    } deframed_t;

    // One stream byte waiting to be sent, tagged with its idling phase.
    typedef struct {
        byte_t data;
        bit    drain_first;
        int    phase;
    } stream_item_t;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    logic   in_stall;
    byte_t  in_byte   = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    byte_t  out_byte;
    logic   last;
    error_t error;

    stream_item_t stream_bytes[$];
    deframed_t    awaited_bytes[$];
    int           build_phase    = 0;
    bit           hold_for_drain = 1'b0;
    int           rx_phase       = 0;
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;

    // Parser state mirrored by the predictor.
    logic   hdr_in_payload;
    count_t hdr_count;
    logic   hdr_digit_seen;
    logic   hdr_overflow;

    decimal_length_prefix_deframer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last),
        .error     (error)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void restart_header();
        hdr_in_payload = 1'b0;
        hdr_count      = '0;
        hdr_digit_seen = 1'b0;
        hdr_overflow   = 1'b0;
    endfunction

    // Feeds one byte through the parser; returns 1 when it yields an output transaction.
    function automatic bit deframe_byte(input byte_t b, output deframed_t res);
        int unsigned acc;
        res.data = '0;
        res.fin  = 1'b0;
        res.err  = ERR_NONE;

        // Inside a payload every byte passes, digits included.
        if (hdr_in_payload) begin
            res.data = b;
            if (hdr_count <= 1) begin
                restart_header();
                res.fin = 1'b1;
            end
            else begin
                hdr_count = hdr_count - 1'b1;
            end
            return 1'b1;
        end

        // Header digit: accumulate, saturating at the maximum payload length.
        if (b >= CHAR_0 && b <= CHAR_9) begin
            acc = hdr_count;
            acc = acc * RADIX + (b - CHAR_0);
            hdr_digit_seen = 1'b1;
            if (hdr_overflow || acc > MAX_PAYLOAD) begin
                hdr_overflow = 1'b1;
                hdr_count    = MAX_PAYLOAD;
            end
            else begin
                hdr_count = acc[15:0];
            end
            return 1'b0;
        end

        // Non-digit ends the header: either an error or the first payload byte.
        if (!hdr_digit_seen) begin
            restart_header();
            res.err = ERR_NO_DIGIT;
            return 1'b1;
        end
        if (hdr_overflow) begin
            restart_header();
            res.err = ERR_TOO_LONG;
            return 1'b1;
        end
        if (hdr_count == 0) begin
            restart_header();
            res.err = ERR_ZERO_LEN;
            return 1'b1;
        end
        res.data = b;
        if (hdr_count == 1) begin
            restart_header();
            res.fin = 1'b1;
            return 1'b1;
        end
        hdr_in_payload = 1'b1;
        hdr_digit_seen = 1'b0;
        hdr_count      = hdr_count - 1'b1;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    // Appends one byte; a change of idling phase also makes the sender wait for a drain.
    task automatic push_byte(input byte_t b);
        stream_item_t item;
        item.data  = b;
        item.phase = (stream_bytes.size() < PHASE_SPAN) ? 0 :
                     (stream_bytes.size() < 2 * PHASE_SPAN) ? 1 : 2;
        item.drain_first = hold_for_drain || (item.phase != build_phase);
        build_phase    = item.phase;
        hold_for_drain = 1'b0;
        stream_bytes.insert(stream_bytes.size(), item);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    function automatic byte_t pick_non_digit();
        byte_t b;
        do
            b = byte_t'($urandom_range(255));
        while (b >= CHAR_0 && b <= CHAR_9);
        return b;
    endfunction

    // Well-formed frame: optional leading zeros, decimal length, then the payload,
    // whose first byte has to be a non-digit to close the header.
    task automatic push_frame(input int len, input int zeros);
        repeat (zeros) push_byte(CHAR_0);
        push_text($sformatf("%0d", len));
        push_byte(pick_non_digit());
        for (int i = 1; i < len; i++)
            push_byte(byte_t'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------
    // Sender: presents the head of the queue, holds it while stalled, and pops
    // it once the transaction is taken.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : drive_stream
        deframed_t res;
        int        gap_pct;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && !in_stall) begin
                if (deframe_byte(in_byte, res))
                    awaited_bytes.insert(awaited_bytes.size(), res);
                void'(stream_bytes.pop_front());
            end
            // Free to present the next byte unless one is still held by a stall.
            if (!in_valid || !in_stall) begin
                if (stream_bytes.size() == 0) begin
                    in_valid <= 1'b0;
                end
                else begin
                    gap_pct = (stream_bytes[0].phase == 0) ? 23 :
                              (stream_bytes[0].phase == 1) ? 84 : 0;
                    if ((stream_bytes[0].drain_first && awaited_bytes.size() != 0)
                        || $urandom_range(99) < gap_pct) begin
                        in_valid <= 1'b0;
                    end
                    else begin
                        in_valid <= 1'b1;
                        in_byte  <= stream_bytes[0].data;
                        rx_phase <= stream_bytes[0].phase;
                    end
                end
            end
        end
    end

    task automatic report_mismatch(input string detail);
        mismatch_count++;
        if (mismatch_count <= MISMATCH_SHOWN)
            $display("mismatch %0d at %0t: %s", mismatch_count, $time, detail);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, compare each accepted transaction with the oldest
    // expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : watch_output
        deframed_t want;
        int        hold_pct;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (awaited_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %h last %b error %0d",
                                              out_byte, last, error));
                end
                else begin
                    want = awaited_bytes.pop_front();
                    if (out_byte !== want.data || last !== want.fin || error !== want.err)
                        report_mismatch($sformatf(
                            "expected byte %h last %b error %0d, got byte %h last %b error %0d",
                            want.data, want.fin, want.err, out_byte, last, error));
                end
            end
            hold_pct  = (rx_phase == 0) ? 84 : (rx_phase == 1) ? 23 : 0;
            out_stall <= ($urandom_range(99) < hold_pct);
        end
    end

    // Hang detection: any transaction on either side resets the count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run_test
        int pick;
        int len;
        int zeros;
        restart_header();

        // Directed part.
        push_byte(8'h3A);           // ':' just above the digits, no header digit
        push_text("0/");            // zero length, closed by '/' just below the digits
        push_text("1");             // one-byte frame: first byte is also the last
        push_byte(8'h00);
        push_text("3");             // digit inside payload passes through
        push_byte(8'hFF);
        push_byte(CHAR_9 - 8'd2);
        push_byte(8'h80);
        push_text("65536q");        // one above the largest length
        push_text("02");            // leading zero
        push_byte(8'h7F);
        push_byte(CHAR_9);

        // Random part: mostly well-formed frames, the rest broken headers and noise.
        hold_for_drain = 1'b1;
        while (stream_bytes.size() < DIRECTED_BYTES + RANDOM_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                len   = ($urandom_range(99) < 85) ? $urandom_range(16, 1)
                                                  : $urandom_range(300, 17);
                zeros = ($urandom_range(99) < 20) ? $urandom_range(2, 1) : 0;
                push_frame(len, zeros);
            end
            else if (pick < 85) begin
                push_byte(pick_non_digit());
            end
            else if (pick < 90) begin
                repeat ($urandom_range(3, 1)) push_byte(CHAR_0);
                push_byte(pick_non_digit());
            end
            else if (pick < 95) begin
                // Oversized length, either a plain number or a long run of nines
                // that keeps going after saturation.
                if ($urandom_range(1))
                    push_text($sformatf("%0d", $urandom_range(9999999, 65536)));
                else
                    repeat ($urandom_range(9, 6)) push_byte(CHAR_9);
                push_byte(pick_non_digit());
            end
            else begin
                repeat ($urandom_range(5, 2)) push_byte(pick_non_digit());
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (stream_bytes.size() != 0 || in_valid || awaited_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_bytes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
